>>> src/i2cmbe_pkg.sv
// Package for the I2C master bit engine: payload structs, command codes,
// register indexes and the sequencer phase type. No dependencies.
package i2cmbe_pkg;

  // Command codes carried in the func field.
  localparam logic [2:0] FUNC_START = 3'd0;
  localparam logic [2:0] FUNC_STOP  = 3'd1;
  localparam logic [2:0] FUNC_WRITE = 3'd2;
  localparam logic [2:0] FUNC_WACK  = 3'd3;
  localparam logic [2:0] FUNC_READ  = 3'd4;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_US   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_POLL_LIMIT = 8'd1;

  // Register reset values.
  localparam logic [7:0] TICKS_PER_US_RST   = 8'd1;
  localparam logic [7:0] ACK_POLL_LIMIT_RST = 8'd250;

  localparam int unsigned DLY_W = 11;

  typedef enum logic [4:0] {
    PH_IDLE = 5'd0,
    PH_ST1  = 5'd1,
    PH_ST2  = 5'd2,
    PH_SP1  = 5'd3,
    PH_SP2  = 5'd4,
    PH_WA1  = 5'd5,
    PH_WA2  = 5'd6,
    PH_WA3  = 5'd7,
    PH_SB1  = 5'd8,
    PH_SB2  = 5'd9,
    PH_SB3  = 5'd10,
    PH_RB1  = 5'd11,
    PH_RB2  = 5'd12,
    PH_AK1  = 5'd13,
    PH_AK2  = 5'd14
  } phase_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] func;
    logic [7:0] wr_data;
    logic       send_ack;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive_en;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rd_data;
    logic       ack_fail;
  } out_item_t;

  // Delay load for a segment of a given number of microsecond units.
  function automatic logic [DLY_W-1:0] seg_ticks(input logic [2:0] units,
                                                 input logic [7:0] tpu);
    logic [DLY_W-1:0] t;
    t = {{(DLY_W-8){1'b0}}, tpu};
    case (units)
      3'd1:    seg_ticks = t;
      3'd2:    seg_ticks = t << 1;
      3'd4:    seg_ticks = t << 2;
      default: seg_ticks = '0;
    endcase
  endfunction

endpackage

>>> src/i2cmbe_core.sv
// Phase sequencer of the I2C master bit engine: state registers and the
// per-tick update. Depends on i2cmbe_pkg.
module i2cmbe_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  i2cmbe_pkg::in_item_t item,
  input  logic [7:0]           ticks_per_us,
  input  logic [7:0]           ack_poll_limit,
  output i2cmbe_pkg::out_item_t res
);

  i2cmbe_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]                  bit_cnt_r, bit_cnt_nxt;
  logic [i2cmbe_pkg::DLY_W-1:0] dly_r, dly_nxt, dly_dec;
  logic [7:0]                  poll_r, poll_nxt;
  logic [7:0]                  shift_r, shift_nxt;
  logic                        ack_choice_r, ack_choice_nxt;
  logic                        scl_r, scl_nxt;
  logic                        sda_r, sda_nxt;
  logic                        en_r, en_nxt;
  logic                        fail_r, fail_nxt;
  logic [7:0]                  rd_r, rd_nxt;
  logic                        done;
  logic [3:0]                  bit_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= i2cmbe_pkg::PH_IDLE;
      bit_cnt_r    <= '0;
      dly_r        <= '0;
      poll_r       <= '0;
      shift_r      <= '0;
      ack_choice_r <= 1'b0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      en_r         <= 1'b1;
      fail_r       <= 1'b0;
      rd_r         <= '0;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      bit_cnt_r    <= bit_cnt_nxt;
      dly_r        <= dly_nxt;
      poll_r       <= poll_nxt;
      shift_r      <= shift_nxt;
      ack_choice_r <= ack_choice_nxt;
      scl_r        <= scl_nxt;
      sda_r        <= sda_nxt;
      en_r         <= en_nxt;
      fail_r       <= fail_nxt;
      rd_r         <= rd_nxt;
    end
  end

  assign dly_dec = (dly_r != '0) ? dly_r - 1'b1 : dly_r;
  assign bit_inc = bit_cnt_r + 4'd1;

  always_comb begin
    phase_nxt      = phase_r;
    bit_cnt_nxt    = bit_cnt_r;
    dly_nxt        = dly_r;
    poll_nxt       = poll_r;
    shift_nxt      = shift_r;
    ack_choice_nxt = ack_choice_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    en_nxt         = en_r;
    fail_nxt       = fail_r;
    rd_nxt         = rd_r;
    done           = 1'b0;

    if (phase_r == i2cmbe_pkg::PH_IDLE) begin
      if (item.cmd_valid) begin
        case (item.func)
          i2cmbe_pkg::FUNC_START: begin
            {scl_nxt, sda_nxt, en_nxt} = 3'b111;
            phase_nxt = i2cmbe_pkg::PH_ST1;
            dly_nxt   = i2cmbe_pkg::seg_ticks(3'd4, ticks_per_us);
          end
          i2cmbe_pkg::FUNC_STOP: begin
            {scl_nxt, sda_nxt, en_nxt} = 3'b001;
            phase_nxt = i2cmbe_pkg::PH_SP1;
            dly_nxt   = i2cmbe_pkg::seg_ticks(3'd4, ticks_per_us);
          end
          i2cmbe_pkg::FUNC_WRITE: begin
            // First bit goes out at once; the byte shifts left behind it.
            bit_cnt_nxt = '0;
            {scl_nxt, sda_nxt, en_nxt} = {1'b0, item.wr_data[7], 1'b1};
            shift_nxt = {item.wr_data[6:0], 1'b0};
            phase_nxt = i2cmbe_pkg::PH_SB1;
            dly_nxt   = i2cmbe_pkg::seg_ticks(3'd2, ticks_per_us);
          end
          i2cmbe_pkg::FUNC_WACK: begin
            fail_nxt  = 1'b0;
            sda_nxt   = 1'b1;
            en_nxt    = 1'b0;
            phase_nxt = i2cmbe_pkg::PH_WA1;
            dly_nxt   = i2cmbe_pkg::seg_ticks(3'd1, ticks_per_us);
          end
          i2cmbe_pkg::FUNC_READ: begin
            ack_choice_nxt = item.send_ack;
            shift_nxt      = '0;
            bit_cnt_nxt    = '0;
            scl_nxt        = 1'b0;
            en_nxt         = 1'b0;
            phase_nxt      = i2cmbe_pkg::PH_RB1;
            dly_nxt        = i2cmbe_pkg::seg_ticks(3'd2, ticks_per_us);
          end
          default: ;
        endcase
      end
    end else begin
      dly_nxt = dly_dec;
      if (dly_dec == '0) begin
        case (phase_r)
          i2cmbe_pkg::PH_ST1: begin
            {scl_nxt, sda_nxt, en_nxt} = 3'b101;
            phase_nxt = i2cmbe_pkg::PH_ST2;
            dly_nxt   = i2cmbe_pkg::seg_ticks(3'd4, ticks_per_us);
          end
          i2cmbe_pkg::PH_ST2: begin
            scl_nxt   = 1'b0;
            phase_nxt = i2cmbe_pkg::PH_IDLE;
            done      = 1'b1;
          end
          i2cmbe_pkg::PH_SP1: begin
            {scl_nxt, sda_nxt, en_nxt} = 3'b111;
            phase_nxt = i2cmbe_pkg::PH_SP2;
            dly_nxt   = i2cmbe_pkg::seg_ticks(3'd4, ticks_per_us);
          end
          i2cmbe_pkg::PH_SP2: begin
            phase_nxt = i2cmbe_pkg::PH_IDLE;
            done      = 1'b1;
          end
          i2cmbe_pkg::PH_WA1: begin
            scl_nxt   = 1'b1;
            phase_nxt = i2cmbe_pkg::PH_WA2;
            dly_nxt   = i2cmbe_pkg::seg_ticks(3'd1, ticks_per_us);
          end
          i2cmbe_pkg::PH_WA2: begin
            poll_nxt  = '0;
            phase_nxt = i2cmbe_pkg::PH_WA3;
            dly_nxt   = '0;
          end
          i2cmbe_pkg::PH_WA3: begin
            if (!item.sda_in) begin
              scl_nxt   = 1'b0;
              phase_nxt = i2cmbe_pkg::PH_IDLE;
              done      = 1'b1;
            end else if (poll_r >= ack_poll_limit) begin
              // Timeout: flag it and run a full stop condition.
              fail_nxt  = 1'b1;
              {scl_nxt, sda_nxt, en_nxt} = 3'b001;
              phase_nxt = i2cmbe_pkg::PH_SP1;
              dly_nxt   = i2cmbe_pkg::seg_ticks(3'd4, ticks_per_us);
            end else begin
              poll_nxt = poll_r + 8'd1;
            end
          end
          i2cmbe_pkg::PH_SB1: begin
            scl_nxt   = 1'b1;
            phase_nxt = i2cmbe_pkg::PH_SB2;
            dly_nxt   = i2cmbe_pkg::seg_ticks(3'd2, ticks_per_us);
          end
          i2cmbe_pkg::PH_SB2: begin
            scl_nxt   = 1'b0;
            phase_nxt = i2cmbe_pkg::PH_SB3;
            dly_nxt   = i2cmbe_pkg::seg_ticks(3'd2, ticks_per_us);
          end
          i2cmbe_pkg::PH_SB3: begin
            bit_cnt_nxt = bit_inc;
            if (bit_inc >= 4'd8) begin
              phase_nxt = i2cmbe_pkg::PH_IDLE;
              done      = 1'b1;
            end else begin
              {scl_nxt, sda_nxt, en_nxt} = {1'b0, shift_r[7], 1'b1};
              shift_nxt = {shift_r[6:0], 1'b0};
              phase_nxt = i2cmbe_pkg::PH_SB1;
              dly_nxt   = i2cmbe_pkg::seg_ticks(3'd2, ticks_per_us);
            end
          end
          i2cmbe_pkg::PH_RB1: begin
            scl_nxt   = 1'b1;
            shift_nxt = {shift_r[6:0], item.sda_in};
            phase_nxt = i2cmbe_pkg::PH_RB2;
            dly_nxt   = i2cmbe_pkg::seg_ticks(3'd1, ticks_per_us);
          end
          i2cmbe_pkg::PH_RB2: begin
            bit_cnt_nxt = bit_inc;
            if (bit_inc >= 4'd8) begin
              {scl_nxt, sda_nxt, en_nxt} = {1'b0, ~ack_choice_r, 1'b1};
              phase_nxt = i2cmbe_pkg::PH_AK1;
            end else begin
              scl_nxt   = 1'b0;
              phase_nxt = i2cmbe_pkg::PH_RB1;
            end
            dly_nxt = i2cmbe_pkg::seg_ticks(3'd2, ticks_per_us);
          end
          i2cmbe_pkg::PH_AK1: begin
            scl_nxt   = 1'b1;
            phase_nxt = i2cmbe_pkg::PH_AK2;
            dly_nxt   = i2cmbe_pkg::seg_ticks(3'd2, ticks_per_us);
          end
          i2cmbe_pkg::PH_AK2: begin
            scl_nxt   = 1'b0;
            rd_nxt    = shift_r;
            phase_nxt = i2cmbe_pkg::PH_IDLE;
            done      = 1'b1;
          end
          default: begin
            phase_nxt = i2cmbe_pkg::PH_IDLE;
          end
        endcase
      end
    end
  end

  always_comb begin
    res.scl_level    = scl_nxt;
    res.sda_level    = sda_nxt;
    res.sda_drive_en = en_nxt;
    res.busy_res     = (phase_nxt != i2cmbe_pkg::PH_IDLE);
    res.done_res     = done;
    res.rd_data      = rd_nxt;
    res.ack_fail     = fail_nxt;
  end

endmodule

>>> src/i2c_master_bit_engine_unit.sv
// Top level of the I2C master bit engine: handshake registers, configuration
// registers and the phase sequencer. Depends on i2cmbe_pkg and i2cmbe_core.
//
//   channel | direction | payload          | handshake
//   --------+-----------+------------------+-----------------------
//   in_     | input     | in_item_t        | in_valid / in_ready
//   out_    | output    | out_item_t       | out_valid / out_ready
//   cfg_    | input     | cfg_index, _data | cfg_valid / cfg_ready
//
// Each tick transfer yields exactly one result transfer; one tick is taken
// every cycle while the result side does not stall. A tick passes the
// input register, the combinational sequencer update and then the result
// register. Reset (rst_n low at a clock edge) returns the lines
// to SCL high, SDA high and driven, and restores the register defaults.
// A stalled result holds the result register; the input register then
// holds its tick and in_ready drops until the result is taken.
module i2c_master_bit_engine_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  i2cmbe_pkg::in_item_t                 in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output i2cmbe_pkg::out_item_t                out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [i2cmbe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [7:0]                           cfg_data
);

  logic                  in_valid_r;
  i2cmbe_pkg::in_item_t  in_data_r;
  logic                  out_valid_r;
  i2cmbe_pkg::out_item_t out_data_r;
  i2cmbe_pkg::out_item_t step_res;
  logic                  advance;
  logic [7:0]            ticks_per_us_r;
  logic [7:0]            ack_poll_limit_r;

  // The buffered tick moves into the sequencer when the result register is
  // free or being emptied this cycle.
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  // Configuration is always accepted; writes to unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_per_us_r   <= i2cmbe_pkg::TICKS_PER_US_RST;
      ack_poll_limit_r <= i2cmbe_pkg::ACK_POLL_LIMIT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == i2cmbe_pkg::CFG_TICKS_PER_US) begin
        ticks_per_us_r <= cfg_data;
      end else if (cfg_index == i2cmbe_pkg::CFG_ACK_POLL_LIMIT) begin
        ack_poll_limit_r <= cfg_data;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_data_r <= in_data;
    end
  end

  i2cmbe_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_en        (advance),
    .item           (in_data_r),
    .ticks_per_us   (ticks_per_us_r),
    .ack_poll_limit (ack_poll_limit_r),
    .res            (step_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= step_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> src/i2cmbe_checker.sv
// Port-level checks for the I2C master bit engine and the bind that
// attaches them to the top level. Depends on i2cmbe_pkg.
module i2cmbe_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input i2cmbe_pkg::out_item_t out_data
);

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A command never completes while still reporting busy.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.done_res && out_data.busy_res))
    else $error("done and busy together");

  // Tick transfers stop only behind a stalled result.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a stalled result");

  // A tick transfer with a free result side shows up behind the input and result registers.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> ##1 out_valid)
    else $error("result missing after tick transfer");

endmodule

bind i2c_master_bit_engine_unit i2cmbe_checker u_i2cmbe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> tb/testbench.sv
// Self-checking testbench for the I2C master bit engine. It drives time-base ticks
// and checks every result against a cycle-free predictor of the bus sequencer.
// Depends on i2cmbe_pkg and i2c_master_bit_engine_unit.
module testbench;

  // The slowest correct run, with every tick and result held up by the longest
  // gaps, stays far below this many cycles.
  localparam int CYCLE_LIMIT = 300000;
  // Random traffic keeps going until this many ticks have been sent in all.
  localparam int TICK_BUDGET = 550;
  localparam int COMMANDS_PER_SETTING = 6;
  localparam int REPORT_CAP = 30;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  i2cmbe_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  i2cmbe_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [i2cmbe_pkg::CFG_IDX_W-1:0] cfg_index = i2cmbe_pkg::CFG_TICKS_PER_US;
  logic [7:0] cfg_data = '0;

  i2c_master_bit_engine_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted engine state. The initial values are the reset state, so the
  // predictor is ready for the first tick once reset has been released.
  logic [7:0] cfg_tpu = i2cmbe_pkg::TICKS_PER_US_RST;
  logic [7:0] cfg_lim = i2cmbe_pkg::ACK_POLL_LIMIT_RST;
  i2cmbe_pkg::phase_t seq_phase = i2cmbe_pkg::PH_IDLE;
  logic [3:0] bit_cnt = '0;
  logic [i2cmbe_pkg::DLY_W-1:0] dly_cnt = '0;
  logic [7:0] poll_cnt = '0;
  logic [7:0] shift_byte = '0;
  logic ack_sel = 1'b0;
  logic scl_q = 1'b1;
  logic sda_q = 1'b1;
  logic en_q = 1'b1;
  logic fail_q = 1'b0;
  logic [7:0] read_byte = '0;

  // Line states still owed by the block, oldest first.
  i2cmbe_pkg::out_item_t line_state_q[$];
  i2cmbe_pkg::out_item_t want;

  // Stimulus knobs. calm turns off all idling on both sides. sda_mode picks
  // the SDA level outside acknowledge polling: 0 low, 1 high, else random.
  // ack_high_left is the number of high SDA samples to give a polling wait
  // before pulling it low; a negative value holds SDA high for good.
  logic calm = 1'b0;
  int sda_mode = 2;
  int ack_high_left = 0;
  int stall_cnt = 0;

  int errors = 0;
  int cycle_count = 0;
  int ticks_taken = 0;
  int cmds_taken = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  int ack_timeouts = 0;

  function automatic void set_lines(input logic scl, input logic sda, input logic en);
    scl_q = scl;
    sda_q = sda;
    en_q = en;
  endfunction

  // Enter a phase that lasts a number of microsecond units; the delay counter
  // keeps only its low bits, as the hardware counter does.
  function automatic void load_segment(input i2cmbe_pkg::phase_t ph, input int units);
    logic [31:0] prod;
    prod = units * cfg_tpu;
    seq_phase = ph;
    dly_cnt = prod[i2cmbe_pkg::DLY_W-1:0];
  endfunction

  function automatic void drive_next_bit();
    set_lines(1'b0, shift_byte[7], 1'b1);
    shift_byte = {shift_byte[6:0], 1'b0};
    load_segment(i2cmbe_pkg::PH_SB1, 2);
  endfunction

  // Apply one tick to the predicted state and return the line state that the
  // block should report for it.
  function automatic i2cmbe_pkg::out_item_t advance_sequencer(input i2cmbe_pkg::in_item_t t);
    i2cmbe_pkg::out_item_t r;
    logic fin;
    fin = 1'b0;
    ticks_taken++;
    if (seq_phase == i2cmbe_pkg::PH_IDLE) begin
      // Only an idle engine looks at the command; unknown codes are dropped.
      if (t.cmd_valid && t.func <= i2cmbe_pkg::FUNC_READ) begin
        cmds_taken++;
        case (t.func)
          i2cmbe_pkg::FUNC_START: begin
            set_lines(1'b1, 1'b1, 1'b1);
            load_segment(i2cmbe_pkg::PH_ST1, 4);
          end
          i2cmbe_pkg::FUNC_STOP: begin
            set_lines(1'b0, 1'b0, 1'b1);
            load_segment(i2cmbe_pkg::PH_SP1, 4);
          end
          i2cmbe_pkg::FUNC_WRITE: begin
            shift_byte = t.wr_data;
            bit_cnt = '0;
            drive_next_bit();
          end
          i2cmbe_pkg::FUNC_WACK: begin
            fail_q = 1'b0;
            set_lines(scl_q, 1'b1, 1'b0);
            load_segment(i2cmbe_pkg::PH_WA1, 1);
          end
          i2cmbe_pkg::FUNC_READ: begin
            ack_sel = t.send_ack;
            shift_byte = '0;
            bit_cnt = '0;
            set_lines(1'b0, sda_q, 1'b0);
            load_segment(i2cmbe_pkg::PH_RB1, 2);
          end
          default: ;
        endcase
      end
    end else begin
      if (dly_cnt != 0) dly_cnt--;
      if (dly_cnt == 0) begin
        case (seq_phase)
          i2cmbe_pkg::PH_ST1: begin
            set_lines(1'b1, 1'b0, 1'b1);
            load_segment(i2cmbe_pkg::PH_ST2, 4);
          end
          i2cmbe_pkg::PH_ST2: begin
            scl_q = 1'b0;
            seq_phase = i2cmbe_pkg::PH_IDLE;
            fin = 1'b1;
          end
          i2cmbe_pkg::PH_SP1: begin
            set_lines(1'b1, 1'b1, 1'b1);
            load_segment(i2cmbe_pkg::PH_SP2, 4);
          end
          i2cmbe_pkg::PH_SP2: begin
            seq_phase = i2cmbe_pkg::PH_IDLE;
            fin = 1'b1;
          end
          i2cmbe_pkg::PH_WA1: begin
            scl_q = 1'b1;
            load_segment(i2cmbe_pkg::PH_WA2, 1);
          end
          i2cmbe_pkg::PH_WA2: begin
            poll_cnt = '0;
            load_segment(i2cmbe_pkg::PH_WA3, 0);
          end
          i2cmbe_pkg::PH_WA3: begin
            // The poll looks at SDA on every tick. Too many high samples
            // give up on the slave and put a stop condition on the bus.
            if (!t.sda_in) begin
              scl_q = 1'b0;
              seq_phase = i2cmbe_pkg::PH_IDLE;
              fin = 1'b1;
            end else if (poll_cnt >= cfg_lim) begin
              fail_q = 1'b1;
              ack_timeouts++;
              set_lines(1'b0, 1'b0, 1'b1);
              load_segment(i2cmbe_pkg::PH_SP1, 4);
            end else begin
              poll_cnt++;
            end
          end
          i2cmbe_pkg::PH_SB1: begin
            scl_q = 1'b1;
            load_segment(i2cmbe_pkg::PH_SB2, 2);
          end
          i2cmbe_pkg::PH_SB2: begin
            scl_q = 1'b0;
            load_segment(i2cmbe_pkg::PH_SB3, 2);
          end
          i2cmbe_pkg::PH_SB3: begin
            bit_cnt++;
            if (bit_cnt >= 4'd8) begin
              seq_phase = i2cmbe_pkg::PH_IDLE;
              fin = 1'b1;
            end else begin
              drive_next_bit();
            end
          end
          i2cmbe_pkg::PH_RB1: begin
            scl_q = 1'b1;
            shift_byte = {shift_byte[6:0], t.sda_in};
            load_segment(i2cmbe_pkg::PH_RB2, 1);
          end
          i2cmbe_pkg::PH_RB2: begin
            bit_cnt++;
            if (bit_cnt >= 4'd8) begin
              set_lines(1'b0, !ack_sel, 1'b1);
              load_segment(i2cmbe_pkg::PH_AK1, 2);
            end else begin
              scl_q = 1'b0;
              load_segment(i2cmbe_pkg::PH_RB1, 2);
            end
          end
          i2cmbe_pkg::PH_AK1: begin
            scl_q = 1'b1;
            load_segment(i2cmbe_pkg::PH_AK2, 2);
          end
          i2cmbe_pkg::PH_AK2: begin
            scl_q = 1'b0;
            read_byte = shift_byte;
            seq_phase = i2cmbe_pkg::PH_IDLE;
            fin = 1'b1;
          end
          default: seq_phase = i2cmbe_pkg::PH_IDLE;
        endcase
      end
    end
    r.scl_level = scl_q;
    r.sda_level = sda_q;
    r.sda_drive_en = en_q;
    r.busy_res = (seq_phase != i2cmbe_pkg::PH_IDLE);
    r.done_res = fin;
    r.rd_data = read_byte;
    r.ack_fail = fail_q;
    return r;
  endfunction

  // Idle gaps: mostly none, often a few cycles, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // SDA level for the next tick, chosen from the predicted phase so that
  // acknowledge waits end the way the current test wants.
  function automatic logic pick_sda();
    if (seq_phase == i2cmbe_pkg::PH_WA3) begin
      if (ack_high_left == 0) return 1'b0;
      if (ack_high_left > 0) ack_high_left--;
      return 1'b1;
    end
    if (sda_mode == 0) return 1'b0;
    if (sda_mode == 1) return 1'b1;
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic i2cmbe_pkg::in_item_t make_tick(input logic v, input logic [2:0] f,
                                                     input logic [7:0] d, input logic sk);
    i2cmbe_pkg::in_item_t t;
    t.cmd_valid = v;
    t.func = f;
    t.wr_data = d;
    t.send_ack = sk;
    t.sda_in = pick_sda();
    return t;
  endfunction

  // A tick while the engine works; commands on it must be ignored.
  function automatic i2cmbe_pkg::in_item_t busy_tick();
    return make_tick($urandom_range(0, 3) == 0, 3'($urandom_range(0, 7)), 8'($urandom),
                     1'($urandom_range(0, 1)));
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want_v);
    errors++;
    if (errors <= REPORT_CAP)
      $display("[%0t] mismatch on %s: got %0h, expected %0h (result %0d)",
               $time, what, got, want_v, results_seen);
  endtask

  // Offer one tick after a random gap and hold it until the transfer happens.
  // Valid is only raised or lowered once per edge, never both.
  task automatic send_tick(input i2cmbe_pkg::in_item_t t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    line_state_q.push_back(advance_sequencer(t));
  endtask

  // Issue one command from idle, sometimes after a few empty ticks, and keep
  // ticking until the predicted engine is idle again.
  task automatic run_cmd(input logic [2:0] f, input logic [7:0] d, input logic sk);
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) send_tick(make_tick(1'b0, f, d, sk));
    send_tick(make_tick(1'b1, f, d, sk));
    while (seq_phase != i2cmbe_pkg::PH_IDLE) send_tick(busy_tick());
  endtask

  // Bring the engine to idle and wait until every owed result has arrived.
  task automatic settle();
    while (seq_phase != i2cmbe_pkg::PH_IDLE) send_tick(busy_tick());
    in_valid <= 1'b0;
    while (line_state_q.size() != 0) @(posedge clk);
  endtask

  // Write both registers back to back; valid stays high between the two
  // transfers and only the payload moves on.
  task automatic write_regs(input logic [7:0] tpu, input logic [7:0] lim);
    cfg_valid <= 1'b1;
    cfg_index <= i2cmbe_pkg::CFG_TICKS_PER_US;
    cfg_data <= tpu;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_tpu = tpu;
    cfg_index <= i2cmbe_pkg::CFG_ACK_POLL_LIMIT;
    cfg_data <= lim;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_lim = lim;
    cfg_valid <= 1'b0;
    cfg_writes += 2;
  endtask

  // Register defaults: a short bus transaction with a read of all-ones that
  // sends an ACK, and the unknown command codes.
  task automatic test_reset_defaults();
    sda_mode = 2;
    run_cmd(3'd5, 8'h00, 1'b0);
    run_cmd(3'd6, 8'hFF, 1'b1);
    run_cmd(3'd7, 8'h3C, 1'b0);
    run_cmd(i2cmbe_pkg::FUNC_START, 8'h00, 1'b0);
    run_cmd(i2cmbe_pkg::FUNC_WRITE, 8'hA5, 1'b0);
    ack_high_left = 2;
    run_cmd(i2cmbe_pkg::FUNC_WACK, 8'h00, 1'b0);
    sda_mode = 1;
    run_cmd(i2cmbe_pkg::FUNC_READ, 8'h00, 1'b1);
    sda_mode = 2;
    run_cmd(i2cmbe_pkg::FUNC_STOP, 8'h00, 1'b0);
    settle();
  endtask

  // A zero time base makes every segment a single tick; a zero poll limit
  // fails the wait on its first high sample. The read here sees all-zeros
  // and answers with a NACK.
  task automatic test_single_tick_segments();
    calm = 1'b1;
    write_regs(8'd0, 8'd0);
    run_cmd(i2cmbe_pkg::FUNC_START, 8'h00, 1'b0);
    run_cmd(i2cmbe_pkg::FUNC_WRITE, 8'hFF, 1'b1);
    ack_high_left = 0;
    run_cmd(i2cmbe_pkg::FUNC_WACK, 8'h00, 1'b0);
    ack_high_left = 1;
    run_cmd(i2cmbe_pkg::FUNC_WACK, 8'h00, 1'b0);
    sda_mode = 0;
    run_cmd(i2cmbe_pkg::FUNC_READ, 8'h00, 1'b0);
    sda_mode = 2;
    ack_high_left = 0;
    run_cmd(i2cmbe_pkg::FUNC_WACK, 8'h00, 1'b0);
    run_cmd(i2cmbe_pkg::FUNC_STOP, 8'h00, 1'b0);
    calm = 1'b0;
    settle();
  endtask

  // The last high sample that still passes, the first that fails, the flag
  // staying up across another command, and a wait that never gets an answer.
  task automatic test_ack_poll_bounds();
    write_regs(8'd1, 8'd3);
    ack_high_left = 3;
    run_cmd(i2cmbe_pkg::FUNC_WACK, 8'h00, 1'b0);
    ack_high_left = 4;
    run_cmd(i2cmbe_pkg::FUNC_WACK, 8'h00, 1'b0);
    run_cmd(i2cmbe_pkg::FUNC_STOP, 8'h00, 1'b0);
    ack_high_left = 0;
    run_cmd(i2cmbe_pkg::FUNC_WACK, 8'h00, 1'b0);
    settle();
    write_regs(8'd1, 8'd10);
    ack_high_left = -1;
    run_cmd(i2cmbe_pkg::FUNC_WACK, 8'h00, 1'b0);
    settle();
  endtask

  // A slower time base stretches every segment over many ticks.
  task automatic test_slow_time_base();
    write_regs(8'd8, 8'd1);
    run_cmd(i2cmbe_pkg::FUNC_START, 8'h00, 1'b0);
    ack_high_left = 1;
    run_cmd(i2cmbe_pkg::FUNC_WACK, 8'h00, 1'b0);
    settle();
  endtask

  // Mostly well-formed transactions (start, address, acknowledge, data,
  // stop) with random content, plus loose commands in any order.
  task automatic test_random_traffic();
    int cfg_mark;
    int r;
    logic [7:0] tpu;
    logic [7:0] lim;
    cfg_mark = cmds_taken;
    write_regs(8'd0, 8'd2);
    while (ticks_taken < TICK_BUDGET) begin
      if (cmds_taken - cfg_mark >= COMMANDS_PER_SETTING) begin
        settle();
        r = $urandom_range(0, 9);
        tpu = (r < 6) ? 8'd0 : 8'd1;
        r = $urandom_range(0, 9);
        lim = (r < 2) ? 8'd0 : (r < 4) ? 8'd1 : 8'($urandom_range(2, 6));
        write_regs(tpu, lim);
        cfg_mark = cmds_taken;
      end
      calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 9);
      sda_mode = (r == 0) ? 0 : (r == 1) ? 1 : 2;
      // Acknowledge outcome for this transaction: a quick answer, the last
      // sample the limit allows, one sample too many, or no answer at all.
      r = $urandom_range(0, 9);
      if (r < 6) ack_high_left = $urandom_range(0, (cfg_lim < 4) ? cfg_lim : 4);
      else if (r < 8) ack_high_left = cfg_lim;
      else if (r < 9) ack_high_left = cfg_lim + 1;
      else ack_high_left = -1;
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4))
          run_cmd(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom_range(0, 1)));
      end else begin
        run_cmd(i2cmbe_pkg::FUNC_START, 8'($urandom), 1'($urandom_range(0, 1)));
        run_cmd(i2cmbe_pkg::FUNC_WRITE, 8'($urandom), 1'($urandom_range(0, 1)));
        run_cmd(i2cmbe_pkg::FUNC_WACK, 8'($urandom), 1'($urandom_range(0, 1)));
        repeat ($urandom_range(0, 1)) begin
          if ($urandom_range(0, 1)) begin
            run_cmd(i2cmbe_pkg::FUNC_WRITE, 8'($urandom), 1'($urandom_range(0, 1)));
            ack_high_left = $urandom_range(0, 2);
            run_cmd(i2cmbe_pkg::FUNC_WACK, 8'($urandom), 1'($urandom_range(0, 1)));
          end else begin
            run_cmd(i2cmbe_pkg::FUNC_READ, 8'($urandom), 1'($urandom_range(0, 1)));
          end
        end
        run_cmd(i2cmbe_pkg::FUNC_STOP, 8'($urandom), 1'($urandom_range(0, 1)));
      end
    end
    calm = 1'b0;
    settle();
  endtask

  // Result side: random stalls on out_ready; no new stall starts while calm is set.
  always @(posedge clk) begin
    if (stall_cnt > 0) stall_cnt--;
    else if (!calm && $urandom_range(0, 3) == 0) stall_cnt = pick_gap();
    out_ready <= (stall_cnt == 0);
  end

  // Each result transfer is matched against the oldest owed line state.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (line_state_q.size() == 0) begin
        report_mismatch("result with none owed", 8'h00, 8'h00);
      end else begin
        want = line_state_q.pop_front();
        results_seen++;
        if (out_data.scl_level !== want.scl_level)
          report_mismatch("scl_level", 8'(out_data.scl_level), 8'(want.scl_level));
        if (out_data.sda_level !== want.sda_level)
          report_mismatch("sda_level", 8'(out_data.sda_level), 8'(want.sda_level));
        if (out_data.sda_drive_en !== want.sda_drive_en)
          report_mismatch("sda_drive_en", 8'(out_data.sda_drive_en),
                          8'(want.sda_drive_en));
        if (out_data.busy_res !== want.busy_res)
          report_mismatch("busy_res", 8'(out_data.busy_res), 8'(want.busy_res));
        if (out_data.done_res !== want.done_res)
          report_mismatch("done_res", 8'(out_data.done_res), 8'(want.done_res));
        if (out_data.rd_data !== want.rd_data)
          report_mismatch("rd_data", out_data.rd_data, want.rd_data);
        if (out_data.ack_fail !== want.ack_fail)
          report_mismatch("ack_fail", 8'(out_data.ack_fail), 8'(want.ack_fail));
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    // Synchronous reset held low from the start and released once.
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_single_tick_segments();
    test_ack_poll_bounds();
    test_slow_time_base();
    test_random_traffic();
    // Give a stray extra result time to show up before judging the run.
    repeat (4) @(posedge clk);
    $display("Covered %0d ticks carrying %0d accepted commands, %0d results checked.",
             ticks_taken, cmds_taken, results_seen);
    $display("Register writes: %0d, acknowledge timeouts: %0d, mismatches: %0d.",
             cfg_writes, ack_timeouts, errors);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
